// File: hw/rtl/ssrrip_pkg.sv
// Shared types and constants for the streaming-aware RRIP replacement block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package ssrrip_pkg;
  localparam int unsigned NumSets    = 2048;
  localparam int unsigned NumWays    = 16;
  localparam int unsigned SigBits    = 6;
  localparam int unsigned AddrBits   = 48;
  localparam int unsigned SetW       = $clog2(NumSets);
  localparam int unsigned WayW       = $clog2(NumWays);
  localparam int unsigned SigEntries = 1 << SigBits;
  localparam int unsigned StrideW    = AddrBits + 1;
  localparam int unsigned StrdRowW   = AddrBits + StrideW + 2;
  localparam int unsigned CntW       = 20;
  localparam int unsigned QDepth     = 2;

  localparam logic [1:0]      RrpvMax        = 2'd3;
  localparam logic [1:0]      CtrMax         = 2'd3;
  localparam logic [1:0]      CtrReset       = 2'd1;
  localparam logic [CntW-1:0] ResetDecay     = 20'd100000;
  localparam logic [1:0]      ResetStreamThr = 2'd2;
  localparam logic [1:0]      ResetReuseThr  = 2'd2;
  localparam logic            ModeVictim     = 1'b0;

  typedef enum logic [1:0] {
    CfgDecay  = 2'd0,
    CfgStream = 2'd1,
    CfgReuse  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLook,
    StDecay,
    StRead,
    StExec
  } back_state_e;

  typedef struct packed {
    logic        mode;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [47:0] address;
    logic [5:0]  signature;
    logic        hit;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       streaming;
    logic [1:0] insert_rrpv;
  } rsp_t;

  typedef struct packed {
    logic [CntW-1:0] decay_len;
    logic [1:0]      stream_thr;
    logic [1:0]      reuse_thr;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/ship_streaming_rrip_replacement.sv
// Top level of the streaming-aware RRIP replacement block: configuration registers and wiring.
// Depends on ssrrip_pkg, ssrrip_front, ssrrip_back and ssrrip_rsp_q.
//
//   channel   direction  handshake              payload
//   request   in         push / full            req_i (req_t)
//   response  out        pop / empty            rsp_o (rsp_t)
//   config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A victim request in the engine first reads the set row, then ages it.
// An update goes through a row read, a reuse counter lookup, then the row and counter writes.
// An update that triggers decay adds a sweep that lowers all 64 reuse counters one by one.
// After reset a clearing pass writes all 2048 set rows, one per cycle; full stays high meanwhile.
// Requests and responses each pass through a two-entry queue, so either side may stall.
`default_nettype none
module ship_streaming_rrip_replacement (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  ssrrip_pkg::req_t req_i,
  input  wire              push,
  output logic             full,
  output ssrrip_pkg::rsp_t rsp_o,
  output logic             empty,
  input  wire              pop,
  input  wire              cfg_we_i,
  input  wire [1:0]        cfg_idx_i,
  input  wire [19:0]       cfg_wdata_i
);
  import ssrrip_pkg::*;

  cfg_t  cfg_q;
  stat_t stat;
  req_t  cmd;
  rsp_t  eng_rsp;
  logic  cmd_valid, cmd_pop, rsp_space, rsp_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_len  <= ResetDecay;
      cfg_q.stream_thr <= ResetStreamThr;
      cfg_q.reuse_thr  <= ResetReuseThr;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDecay:  cfg_q.decay_len  <= cfg_wdata_i;
        CfgStream: cfg_q.stream_thr <= cfg_wdata_i[1:0];
        CfgReuse:  cfg_q.reuse_thr  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  ssrrip_front u_front (
    .clk_i,
    .rst_ni,
    .req_i,
    .push,
    .full,
    .clearing_i  (stat.clearing),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  ssrrip_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .rsp_space_i (rsp_space),
    .rsp_valid_o (rsp_push),
    .rsp_o       (eng_rsp),
    .stat_o      (stat)
  );

  ssrrip_rsp_q u_rsp_q (
    .clk_i,
    .rst_ni,
    .push_i  (rsp_push),
    .rsp_i   (eng_rsp),
    .space_o (rsp_space),
    .rsp_o,
    .empty,
    .pop
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push |-> rsp_space) else $error("response pushed into a full queue");
  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> (!rsp_push && !cmd_pop)) else $error("engine active during clearing");
  a_full_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> full) else $error("requests accepted during clearing");
  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> stat.busy) else $error("popped request did not start the engine");
endmodule
`default_nettype wire

// File: hw/rtl/ssrrip_front.sv
// Request front end: a short queue that accepts requests and holds them for the engine.
// Depends on ssrrip_pkg.
`default_nettype none
module ssrrip_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  ssrrip_pkg::req_t req_i,
  input  wire              push,
  output logic             full,
  input  wire              clearing_i,
  output ssrrip_pkg::req_t cmd_o,
  output logic             cmd_valid_o,
  input  wire              cmd_pop_i
);
  import ssrrip_pkg::*;

  req_t       mem_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept;

  assign full        = (cnt_q == 2'(QDepth)) || clearing_i;
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) mem_q[wr_ptr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(accept) - 2'(cmd_pop_i);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ssrrip_back.sv
// Replacement engine: set metadata memories, reuse counters, stride detector and sequencer.
// Depends on ssrrip_pkg.
`default_nettype none
module ssrrip_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  ssrrip_pkg::cfg_t cfg_i,
  input  ssrrip_pkg::req_t cmd_i,
  input  wire              cmd_valid_i,
  output logic             cmd_pop_o,
  input  wire              rsp_space_i,
  output logic             rsp_valid_o,
  output ssrrip_pkg::rsp_t rsp_o,
  output ssrrip_pkg::stat_t stat_o
);
  import ssrrip_pkg::*;

  logic [NumWays*2-1:0]       rrpv_mem [NumSets];
  logic [NumWays*SigBits-1:0] sig_mem  [NumSets];
  logic [StrdRowW-1:0]        strd_mem [NumSets];
  logic [1:0]                 ctr_mem  [SigEntries];

  logic [NumWays*2-1:0]       rrpv_rd_q;
  logic [NumWays*SigBits-1:0] sig_rd_q;
  logic [StrdRowW-1:0]        strd_rd_q;
  logic [1:0]                 ctr_a_q, ctr_b_q;

  back_state_e state_q, state_d;
  logic [SetW-1:0] clr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SigBits:0] dk_q, dk_dec;
  req_t            cmd_q;

  logic                       start, exec, clr_en, upd, look, sweep, reread;
  logic [SetW-1:0]            rd_set, ex_set, wr_set;
  logic [WayW-1:0]            ex_way;
  logic [SigBits-1:0]         old_sig, new_sig;
  logic [1:0]                 r [NumWays];
  logic [1:0]                 aged [NumWays];
  logic                       any3, any2, any1;
  logic [1:0]                 add;
  logic [WayW-1:0]            victim;
  logic [AddrBits-1:0]        prev_addr;
  logic [StrideW-1:0]         prev_stride, stride;
  logic [1:0]                 conf, conf_n;
  logic                       streaming, decay;
  logic [CntW-1:0]            cnt_inc;
  logic [1:0]                 ins;
  logic [1:0]                 ctr_old_n, ctr_new, ctr_wd;
  logic [SigBits-1:0]         ctr_ra, ctr_wa;
  logic                       ctr_rd, ctr_we;
  logic [NumWays*2-1:0]       rrpv_wr;
  logic [NumWays*SigBits-1:0] sig_wr;
  logic [StrdRowW-1:0]        strd_wr;
  logic                       rrpv_we, sig_we, strd_we;

  assign rd_set = cmd_i.set_index[SetW-1:0];
  assign ex_set = cmd_q.set_index[SetW-1:0];
  assign ex_way = cmd_q.way[WayW-1:0];
  assign upd    = (cmd_q.mode != ModeVictim);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == SetW'(NumSets - 1)) state_d = StIdle;
      StIdle: begin
        if (cmd_valid_i && rsp_space_i) begin
          state_d = (cmd_i.mode == ModeVictim) ? StExec : StLook;
        end
      end
      StLook:  state_d = decay ? StDecay : StExec;
      StDecay: if (dk_q == (SigBits+1)'(SigEntries)) state_d = StRead;
      StRead:  state_d = StExec;
      StExec:  state_d = StIdle;
      default: state_d = StClear;
    endcase
  end

  always_comb begin
    start  = (state_q == StIdle) && cmd_valid_i && rsp_space_i;
    exec   = (state_q == StExec);
    clr_en = (state_q == StClear);
    look   = (state_q == StLook);
    sweep  = (state_q == StDecay);
    reread = (state_q == StRead);
  end

  assign cmd_pop_o       = start;
  assign rsp_valid_o     = exec;
  assign stat_o.clearing = clr_en;
  assign stat_o.busy     = !clr_en && (state_q != StIdle);

  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NumWays; w++) begin
      r[w] = rrpv_rd_q[2*w +: 2];
      any3 = any3 | (r[w] == 2'd3);
      any2 = any2 | (r[w] == 2'd2);
      any1 = any1 | (r[w] == 2'd1);
    end
    add = any3 ? 2'd0 : (any2 ? 2'd1 : (any1 ? 2'd2 : 2'd3));
    victim = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      aged[w] = r[w] + add;
      if (aged[w] == RrpvMax) victim = WayW'(w);
    end
  end

  always_comb begin
    prev_addr   = strd_rd_q[AddrBits-1:0];
    prev_stride = strd_rd_q[AddrBits +: StrideW];
    conf        = strd_rd_q[StrdRowW-1 -: 2];
    stride      = {1'b0, cmd_q.address} - {1'b0, prev_addr};
    if ((prev_stride != '0) && (stride == prev_stride)) begin
      conf_n = (conf == 2'd3) ? conf : conf + 2'd1;
    end else begin
      conf_n = (conf == 2'd0) ? conf : conf - 2'd1;
    end
    streaming = (conf_n >= cfg_i.stream_thr);
    strd_wr   = {conf_n, stride, cmd_q.address};
  end

  always_comb begin
    cnt_inc = cnt_q + CntW'(1);
    decay   = (cnt_inc == cfg_i.decay_len);
    cnt_d   = decay ? '0 : cnt_inc;
    old_sig = sig_rd_q[ex_way*SigBits +: SigBits];
    new_sig = cmd_q.signature[SigBits-1:0];
    ctr_new = ctr_b_q;
    if (cmd_q.hit) begin
      ctr_old_n = (ctr_a_q == CtrMax) ? ctr_a_q : ctr_a_q + 2'd1;
      ins = 2'd0;
    end else begin
      ctr_old_n = (ctr_a_q == 2'd0) ? ctr_a_q : ctr_a_q - 2'd1;
      if (new_sig == old_sig) ctr_new = ctr_old_n;
      ins = (streaming || (ctr_new < cfg_i.reuse_thr)) ? RrpvMax : 2'd0;
    end
  end

  always_comb begin
    dk_dec = dk_q - (SigBits+1)'(1);
    ctr_rd = look || reread || sweep;
    ctr_ra = sweep ? dk_q[SigBits-1:0] : old_sig;
    ctr_we = 1'b0;
    ctr_wa = old_sig;
    ctr_wd = ctr_old_n;
    if (clr_en) begin
      ctr_we = 1'b1;
      ctr_wa = clr_q[SigBits-1:0];
      ctr_wd = CtrReset;
    end else if (sweep && (dk_q != '0)) begin
      ctr_we = 1'b1;
      ctr_wa = dk_dec[SigBits-1:0];
      ctr_wd = (ctr_a_q == 2'd0) ? ctr_a_q : ctr_a_q - 2'd1;
    end else if (exec && upd) begin
      ctr_we = 1'b1;
    end
  end

  always_comb begin
    rrpv_wr = rrpv_rd_q;
    sig_wr  = sig_rd_q;
    if (upd) begin
      rrpv_wr[ex_way*2 +: 2] = ins;
      sig_wr[ex_way*SigBits +: SigBits] = new_sig;
    end else begin
      for (int w = 0; w < NumWays; w++) rrpv_wr[2*w +: 2] = aged[w];
    end
    if (clr_en) begin
      rrpv_wr = {NumWays{RrpvMax}};
      sig_wr  = '0;
    end
    wr_set  = clr_en ? clr_q : ex_set;
    rrpv_we = clr_en || exec;
    sig_we  = clr_en || (exec && upd && !cmd_q.hit);
    strd_we = clr_en || (exec && upd);
  end

  always_comb begin
    rsp_o = '0;
    if (upd) begin
      rsp_o.streaming   = streaming;
      rsp_o.insert_rrpv = ins;
    end else begin
      rsp_o.victim_way  = 4'(victim);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rrpv_we) rrpv_mem[wr_set] <= rrpv_wr;
    if (start) rrpv_rd_q <= rrpv_mem[rd_set];
  end

  always_ff @(posedge clk_i) begin
    if (sig_we) sig_mem[wr_set] <= sig_wr;
    if (start) sig_rd_q <= sig_mem[rd_set];
  end

  always_ff @(posedge clk_i) begin
    if (strd_we) strd_mem[wr_set] <= clr_en ? '0 : strd_wr;
    if (start) strd_rd_q <= strd_mem[rd_set];
  end

  always_ff @(posedge clk_i) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    if (ctr_rd) ctr_a_q <= ctr_mem[ctr_ra];
    if (look || reread) ctr_b_q <= ctr_mem[new_sig];
  end

  always_ff @(posedge clk_i) begin
    if (start) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      cnt_q   <= '0;
      dk_q    <= '0;
    end else begin
      state_q <= state_d;
      if (clr_en) clr_q <= clr_q + SetW'(1);
      if (sweep) dk_q <= (dk_q == (SigBits+1)'(SigEntries)) ? '0 : dk_q + (SigBits+1)'(1);
      if (exec && upd) cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ssrrip_rsp_q.sv
// Result queue that holds finished responses until the consumer pops them.
// Depends on ssrrip_pkg.
`default_nettype none
module ssrrip_rsp_q (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  ssrrip_pkg::rsp_t rsp_i,
  output logic             space_o,
  output ssrrip_pkg::rsp_t rsp_o,
  output logic             empty,
  input  wire              pop
);
  import ssrrip_pkg::*;

  rsp_t       mem_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       take;

  assign empty   = (cnt_q == 2'd0);
  assign space_o = (cnt_q != 2'(QDepth));
  assign take    = pop && !empty;
  assign rsp_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rsp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (take) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(take);
    end
  end
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for ship_streaming_rrip_replacement: random and directed requests
// are checked against a behavioral predictor of the replacement policy.
// Depends on ssrrip_pkg and the block's RTL.
`default_nettype none
module testbench;
  import ssrrip_pkg::*;

  class policy_scoreboard;
    logic [1:0]          rrpv [NumSets*NumWays];
    logic [5:0]          way_sig [NumSets*NumWays];
    logic [1:0]          reuse [SigEntries];
    logic [47:0]         seen_addr [NumSets];
    logic [48:0]         last_stride [NumSets];
    logic [1:0]          conf [NumSets];
    logic [19:0]         upd_cnt;
    logic [19:0]         decay_per;
    logic [1:0]          stream_thr;
    logic [1:0]          reuse_thr;
    rsp_t                pending [$];
    int                  errors;

    function new();
      foreach (rrpv[i]) rrpv[i] = RrpvMax;
      foreach (way_sig[i]) way_sig[i] = '0;
      foreach (reuse[i]) reuse[i] = CtrReset;
      foreach (seen_addr[i]) seen_addr[i] = '0;
      foreach (last_stride[i]) last_stride[i] = '0;
      foreach (conf[i]) conf[i] = '0;
      upd_cnt = '0;
      decay_per = ResetDecay;
      stream_thr = ResetStreamThr;
      reuse_thr = ResetReuseThr;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [19:0] val);
      case (idx)
        CfgDecay:  decay_per = val;
        CfgStream: stream_thr = val[1:0];
        CfgReuse:  reuse_thr = val[1:0];
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      rsp_t exp;
      int unsigned base;
      int unsigned ln;
      logic [1:0] top;
      logic [48:0] stride;
      logic stream;
      logic [5:0] old;
      exp = '0;
      base = r.set_index * NumWays;
      ln = base + r.way;
      if (r.mode == ModeVictim) begin
        top = 2'd0;
        for (int w = 0; w < NumWays; w++) if (rrpv[base+w] > top) top = rrpv[base+w];
        if (top < RrpvMax)
          for (int w = 0; w < NumWays; w++) rrpv[base+w] = rrpv[base+w] + (RrpvMax - top);
        for (int w = NumWays - 1; w >= 0; w--)
          if (rrpv[base+w] == RrpvMax) exp.victim_way = w[3:0];
      end else begin
        upd_cnt = upd_cnt + 20'd1;
        stride = {1'b0, r.address} - {1'b0, seen_addr[r.set_index]};
        if (last_stride[r.set_index] != 0 && stride == last_stride[r.set_index]) begin
          if (conf[r.set_index] < 3) conf[r.set_index]++;
        end else if (conf[r.set_index] > 0) begin
          conf[r.set_index]--;
        end
        last_stride[r.set_index] = stride;
        seen_addr[r.set_index] = r.address;
        stream = conf[r.set_index] >= stream_thr;
        if (upd_cnt == decay_per) begin
          upd_cnt = '0;
          foreach (reuse[i]) if (reuse[i] > 0) reuse[i]--;
        end
        old = way_sig[ln];
        if (r.hit) begin
          rrpv[ln] = 2'd0;
          if (reuse[old] < CtrMax) reuse[old]++;
          exp.insert_rrpv = 2'd0;
        end else begin
          if (reuse[old] > 0) reuse[old]--;
          exp.insert_rrpv = (stream || reuse[r.signature] < reuse_thr) ? RrpvMax : 2'd0;
          rrpv[ln] = exp.insert_rrpv;
          way_sig[ln] = r.signature;
        end
        exp.streaming = stream;
      end
      pending.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        report("response with nothing expected", got, '0);
        return;
      end
      exp = pending.pop_front();
      if (got.victim_way !== exp.victim_way) report("victim_way", got, exp);
      if (got.streaming !== exp.streaming) report("streaming", got, exp);
      if (got.insert_rrpv !== exp.insert_rrpv) report("insert_rrpv", got, exp);
    endfunction

    function void report(string what, rsp_t got, rsp_t exp);
      errors++;
      if (errors <= 40) $display("mismatch %s: got %h expected %h", what, got, exp);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  req_t        req_i = '0;
  logic        push = 0;
  logic        full;
  rsp_t        rsp_o;
  logic        empty;
  logic        pop = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [19:0] cfg_wdata_i = '0;

  policy_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  ship_streaming_rrip_replacement u_dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && !empty && pop) sb.check_response(rsp_o);
    pop <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("timeout waiting for a handshake");
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 0;
      do @(posedge clk_i); while (send_idle > 0 && $urandom_range(99) < send_idle);
    end
    push <= 1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    sb.note_request(r);
  endtask

  task automatic drain();
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_register(cfg_idx_e idx, logic [19:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [19:0] dval, logic [19:0] sval, logic [19:0] rval);
    set_register(CfgDecay, dval);
    set_register(CfgStream, sval);
    set_register(CfgReuse, rval);
    cfg_we_i <= 0;
  endtask

  function automatic req_t random_request(int unsigned set_max, logic [47:0] addr);
    req_t r;
    r.mode = 1'($urandom_range(1));
    r.set_index = 11'($urandom_range(set_max));
    r.way = 4'($urandom_range(15));
    r.address = addr;
    r.signature = 6'($urandom_range(63));
    r.hit = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic random_phase(int n);
    req_t r;
    logic [47:0] base;
    logic [47:0] step;
    int unsigned s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) begin
        s = $urandom_range(7);
        base = 48'({$urandom, $urandom});
        step = $urandom_range(1) ? 48'd64 : 48'({$urandom, $urandom});
        for (int k = 0; k < 6; k++) begin
          r = random_request(7, base + step * k);
          r.set_index = 11'(s);
          if (k % 2 == 0) r.mode = 1'b1;
          send_request(r);
        end
      end else begin
        send_request(random_request(2047, 48'({$urandom, $urandom})));
      end
    end
  endtask

  initial begin
    req_t r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    // Directed part: extremes, both modes, hit and fill, streaming.
    r = '0;
    send_request(r);
    r = '1; r.mode = 1'b0;
    send_request(r);
    r = '1; r.hit = 1'b0;
    send_request(r);
    r = '1;
    send_request(r);
    r = '0; r.mode = 1'b1; r.way = 4'd15; r.signature = 6'd63; r.hit = 1'b0;
    send_request(r);
    for (int k = 0; k < 5; k++) begin
      r = '0; r.mode = 1'b1; r.set_index = 11'd5; r.address = 48'h1000 * k; r.hit = 1'b0;
      r.way = 4'(k); r.signature = 6'd7;
      send_request(r);
    end
    for (int k = 0; k < 4; k++) begin
      r = '0; r.mode = 1'b1; r.set_index = 11'd9; r.way = 4'd2; r.signature = 6'd3;
      r.hit = 1'b1;
      r.address = 48'hFFFF_FFFF_FFFF - k;
      send_request(r);
    end
    r = '0; r.set_index = 11'd9;
    send_request(r);
    r = '0; r.set_index = 11'd2047; r.address = 48'h8000_0000_0000;
    send_request(r);
    drain();

    configure(20'd1, 20'd0, 20'd0);
    random_phase(70);
    drain();
    configure(20'hFFFFF, 20'd3, 20'd3);
    send_idle = 74;
    random_phase(70);
    drain();
    configure(20'd0, 20'd1, 20'd1);
    send_idle = 0;
    recv_stall = 74;
    random_phase(70);
    drain();
    configure(20'd7, 20'd2, 20'd2);
    send_idle = 25;
    recv_stall = 25;
    random_phase(60);
    send_idle = 0;
    recv_stall = 0;
    random_phase(20);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
